@@ hdl/fault_code_blink_sequencer_macros.svh @@
// assertion macros used by the fault code blink sequencer checker
`ifndef FAULT_CODE_BLINK_SEQUENCER_MACROS_SVH
`define FAULT_CODE_BLINK_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define FCBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define FCBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/fcbs_pkg.sv @@
// types, constants and helpers for the fault code blink sequencer
`timescale 1ns / 1ps
`default_nettype none

package fcbs_pkg;

    localparam int TimerW     = 11;
    localparam int RoundsW    = 4;
    localparam int PreambleW  = 3;
    localparam int CodeW      = 4;
    localparam int CodeLeftW  = 5;
    localparam int CfgAddrW   = 3;
    localparam int CfgDataW   = 11;
    localparam int InDataW    = 8;
    localparam int InUserW    = 1;
    localparam int OutDataW   = 8;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ON    = 3'd1,
        PH_OFF   = 3'd2,
        PH_GAP   = 3'd3,
        PH_PAUSE = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        REQ_NONE   = 2'd0,
        REQ_SYSTEM = 2'd1,
        REQ_LOADER = 2'd2
    } t_req;

    typedef enum logic [CfgAddrW-1:0] {
        REG_SHORT_FLASH = 3'd0,
        REG_CODE_FLASH  = 3'd1,
        REG_GAP         = 3'd2,
        REG_PAUSE       = 3'd3,
        REG_ROUNDS      = 3'd4,
        REG_PREAMBLE    = 3'd5,
        REG_TO_LOADER   = 3'd6
    } t_reg_addr;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef struct packed {
        logic [7:0]           short_flash_ms;
        logic [7:0]           code_flash_ms;
        logic [9:0]           gap_ms;
        logic [10:0]          pause_ms;
        logic [RoundsW-1:0]   round_count;
        logic [PreambleW-1:0] preamble_count;
        logic                 to_loader;
    } t_cfg;

    typedef struct packed {
        t_phase                phase;
        logic [TimerW-1:0]     tick_timer;
        logic [RoundsW-1:0]    rounds_left;
        logic [PreambleW-1:0]  preamble_left;
        logic [CodeLeftW-1:0]  code_left;
        logic [CodeW-1:0]      saved_code;
    } t_seq_state;

    typedef struct packed {
        t_req reset_request;
        logic busy_res;
        logic beep;
        logic led_b;
        logic led_a;
    } t_result;

    function automatic logic [TimerW-1:0] at_least_one(input logic [TimerW-1:0] v);
        return (v == '0) ? TimerW'(1) : v;
    endfunction

endpackage

`default_nettype wire

@@ hdl/fcbs_step.sv @@
// next-state and result logic for one command or tick word
`timescale 1ns / 1ps
`default_nettype none

module fcbs_step (
    input  fcbs_pkg::t_seq_state           i_state,
    input  fcbs_pkg::t_cfg                 i_cfg,
    input  logic                           i_cmd,
    input  logic [fcbs_pkg::CodeW-1:0]     i_error_code,
    output fcbs_pkg::t_seq_state           o_state,
    output fcbs_pkg::t_result              o_result
);
    import fcbs_pkg::*;

    logic [TimerW-1:0]    short_dur;
    logic [TimerW-1:0]    code_dur;
    logic [TimerW-1:0]    gap_dur;
    logic [TimerW-1:0]    pause_dur;
    logic [TimerW-1:0]    timer_dec;
    logic [RoundsW-1:0]   rounds_dec;
    logic [PreambleW-1:0] preamble_dec;
    logic [CodeLeftW-1:0] code_dec;
    logic [PreambleW-1:0] preamble_init;
    logic [RoundsW-1:0]   rounds_init;
    t_seq_state           nxt;
    t_req                 req;

    assign short_dur    = at_least_one(TimerW'(i_cfg.short_flash_ms));
    assign code_dur     = at_least_one(TimerW'(i_cfg.code_flash_ms));
    assign gap_dur      = at_least_one(TimerW'(i_cfg.gap_ms));
    assign pause_dur    = at_least_one(i_cfg.pause_ms);
    assign timer_dec    = i_state.tick_timer - TimerW'(1);
    assign rounds_dec   = i_state.rounds_left - RoundsW'(1);
    assign preamble_dec = i_state.preamble_left - PreambleW'(1);
    assign code_dec     = i_state.code_left - CodeLeftW'(1);
    assign preamble_init = (i_cfg.preamble_count == '0) ? PreambleW'(1) : i_cfg.preamble_count;
    assign rounds_init   = (i_cfg.round_count == '0) ? RoundsW'(1) : i_cfg.round_count;

    always_comb begin
        nxt = i_state;
        req = REQ_NONE;
        if (i_cmd == CMD_START) begin
            if (i_state.phase == PH_IDLE) begin
                nxt.saved_code    = i_error_code;
                nxt.rounds_left   = rounds_init;
                nxt.preamble_left = preamble_init;
                nxt.code_left     = CodeLeftW'(i_error_code) + CodeLeftW'(1);
                nxt.phase         = PH_ON;
                nxt.tick_timer    = short_dur;
            end
        end else if (i_state.phase != PH_IDLE) begin
            nxt.tick_timer = timer_dec;
            if (timer_dec == '0) begin
                unique case (i_state.phase)
                    PH_ON: begin
                        nxt.phase      = PH_OFF;
                        nxt.tick_timer = (i_state.preamble_left != '0) ? short_dur : code_dur;
                    end
                    PH_OFF: begin
                        if (i_state.preamble_left != '0) begin
                            nxt.preamble_left = preamble_dec;
                            if (preamble_dec == '0) begin
                                nxt.phase      = PH_GAP;
                                nxt.tick_timer = gap_dur;
                            end else begin
                                nxt.phase      = PH_ON;
                                nxt.tick_timer = short_dur;
                            end
                        end else begin
                            nxt.code_left = code_dec;
                            if (code_dec != '0) begin
                                nxt.phase      = PH_ON;
                                nxt.tick_timer = code_dur;
                            end else begin
                                nxt.phase      = PH_PAUSE;
                                nxt.tick_timer = pause_dur;
                            end
                        end
                    end
                    PH_GAP: begin
                        nxt.phase      = PH_ON;
                        nxt.tick_timer = code_dur;
                    end
                    PH_PAUSE: begin
                        nxt.rounds_left = rounds_dec;
                        if (rounds_dec != '0) begin
                            nxt.preamble_left = preamble_init;
                            nxt.code_left     = CodeLeftW'(i_state.saved_code) + CodeLeftW'(1);
                            nxt.phase         = PH_ON;
                            nxt.tick_timer    = short_dur;
                        end else begin
                            nxt.phase         = PH_IDLE;
                            nxt.tick_timer    = '0;
                            nxt.preamble_left = '0;
                            nxt.code_left     = '0;
                            req = i_cfg.to_loader ? REQ_LOADER : REQ_SYSTEM;
                        end
                    end
                    default: begin
                        nxt.phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_state = nxt;

    always_comb begin
        o_result.busy_res      = (nxt.phase != PH_IDLE);
        o_result.led_b         = (nxt.phase == PH_ON);
        o_result.beep          = (nxt.phase == PH_ON);
        o_result.led_a         = (nxt.phase != PH_IDLE) && (nxt.phase != PH_ON);
        o_result.reset_request = req;
    end

endmodule

`default_nettype wire

@@ hdl/fault_code_blink_sequencer.sv @@
// top level: stream ports, register file, state and output registers
`timescale 1ns / 1ps
`default_nettype none

// Fault code blink sequencer. A start word (tuser = 1) carrying an error code
// begins a run of rounds; tick words (tuser = 0), one per millisecond, advance
// it. Every accepted word yields exactly one result word with the LED, beeper
// and busy levels after that word, and the word that ends the last pause
// carries the reset request. One word is taken per clock cycle; its result
// sits in the output register in the next cycle, and a new word is accepted
// whenever that register is empty or being drained. Starts while busy are
// ignored. Registers may be written at any time the block is idle; the write
// channel is always ready and writes to unknown indexes are dropped.
module fault_code_blink_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [fcbs_pkg::InDataW-1:0]      i_s_axis_tdata,  // [3:0] error_code
    input  logic [fcbs_pkg::InUserW-1:0]      i_s_axis_tuser,  // [0] cmd
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] led_a, [1] led_b, [2] beep, [3] busy_res, [5:4] reset_request
    output logic [fcbs_pkg::OutDataW-1:0]     o_m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fcbs_pkg::CfgAddrW-1:0]     i_cfg_addr,
    input  logic [fcbs_pkg::CfgDataW-1:0]     i_cfg_data
);
    import fcbs_pkg::*;

    t_cfg       r_cfg;
    t_seq_state r_state;
    t_seq_state n_state;
    t_result    n_result;
    t_result    r_result;
    logic       r_out_valid;
    logic       accept;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    fcbs_step u_step (
        .i_state      (r_state),
        .i_cfg        (r_cfg),
        .i_cmd        (i_s_axis_tuser[0]),
        .i_error_code (i_s_axis_tdata[CodeW-1:0]),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_flash_ms <= 8'd50;
            r_cfg.code_flash_ms  <= 8'd250;
            r_cfg.gap_ms         <= 10'd500;
            r_cfg.pause_ms       <= 11'd1000;
            r_cfg.round_count    <= 4'd10;
            r_cfg.preamble_count <= 3'd5;
            r_cfg.to_loader      <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_SHORT_FLASH: r_cfg.short_flash_ms <= i_cfg_data[7:0];
                REG_CODE_FLASH:  r_cfg.code_flash_ms  <= i_cfg_data[7:0];
                REG_GAP:         r_cfg.gap_ms         <= i_cfg_data[9:0];
                REG_PAUSE:       r_cfg.pause_ms       <= i_cfg_data[10:0];
                REG_ROUNDS:      r_cfg.round_count    <= i_cfg_data[RoundsW-1:0];
                REG_PREAMBLE:    r_cfg.preamble_count <= i_cfg_data[PreambleW-1:0];
                REG_TO_LOADER:   r_cfg.to_loader      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= PH_IDLE;
            r_state.tick_timer    <= '0;
            r_state.rounds_left   <= '0;
            r_state.preamble_left <= '0;
            r_state.code_left     <= '0;
            r_state.saved_code    <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OutDataW'(r_result);

endmodule

`default_nettype wire

@@ hdl/fcbs_checker.sv @@
// port-level checks for the fault code blink sequencer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "fault_code_blink_sequencer_macros.svh"

module fcbs_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_s_axis_tready,
    input  logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [fcbs_pkg::OutDataW-1:0]     o_m_axis_tdata
);
    import fcbs_pkg::*;

    // a stalled result word holds
    `FCBS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata),
        "result word changed while stalled")

    // an empty output register never blocks input
    `FCBS_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n,
        !o_m_axis_tvalid, o_s_axis_tready,
        "input stalled with empty output register")

    // led and beeper levels follow phase consistently
    `FCBS_ASSERT_IMP(a_levels, i_clk, i_rst_n,
        o_m_axis_tvalid,
        (o_m_axis_tdata[1] == o_m_axis_tdata[2]) &&
        (o_m_axis_tdata[0] == (o_m_axis_tdata[3] && !o_m_axis_tdata[1])) &&
        (!o_m_axis_tdata[1] || o_m_axis_tdata[3]),
        "inconsistent led or beeper levels")

    // a reset request only comes with the block going idle, and is a legal code
    `FCBS_ASSERT_IMP(a_req_idle, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tdata[5:4] != 2'd0),
        (o_m_axis_tdata[3:0] == 4'd0) && (o_m_axis_tdata[5:4] != 2'd3) &&
        (o_m_axis_tdata[7:6] == 2'd0),
        "reset request while busy or illegal code")

endmodule

bind fault_code_blink_sequencer fcbs_checker u_fcbs_checker (.*);

`default_nettype wire
